// ===== hdl/mcw_pkg.sv =====
// Shared types, constants and helper functions for the maze carving walk unit.
package mcw_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int ROW_AW   = $clog2(MAX_ROWS);
    localparam int ROW_LIM  = (MAX_ROWS - 1) | 1;
    localparam int COL_LIM  = (MAX_COLS - 1) | 1;
    localparam int FLD_W    = 6;
    localparam int PICK_W   = 8;
    localparam int CFG_W    = 6;

    localparam logic [FLD_W-1:0] GRID_ROWS_RST = 6'd11;
    localparam logic [FLD_W-1:0] GRID_COLS_RST = 6'd21;

    typedef logic [1:0] t_cell;
    localparam t_cell CELL_FREE = 2'd0;
    localparam t_cell CELL_WALL = 2'd1;
    localparam t_cell CELL_PATH = 2'd2;
    localparam t_cell CELL_BACK = 2'd3;

    typedef logic [1:0] t_dir;
    localparam t_dir DIR_UP    = 2'd0;
    localparam t_dir DIR_DOWN  = 2'd1;
    localparam t_dir DIR_RIGHT = 2'd2;
    localparam t_dir DIR_LEFT  = 2'd3;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_INIT = 2'd0;
    localparam t_cmd CMD_STEP = 2'd1;
    localparam t_cmd CMD_READ = 2'd2;

    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_GRID_ROWS = 1'b0;
    localparam t_cfg_idx CFG_GRID_COLS = 1'b1;

    // One grid row as stored in one memory word
    typedef t_cell [MAX_COLS-1:0] t_row;

    typedef enum logic [1:0] {
        RS_UP   = 2'd0,
        RS_MID  = 2'd1,
        RS_DN   = 2'd2,
        RS_CELL = 2'd3
    } t_rsel;

    typedef struct packed {
        logic  start;
        logic  sweep;
        t_rsel rd_sel;
        logic  cap_en;
        t_rsel cap_sel;
        logic  decide;
        logic  wr_en;
        t_rsel wr_sel;
        logic  upd_pos;
        logic  load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic in_init;
        logic in_step;
        logic in_read;
        logic done;
        logic sweep_last;
        logic any_move;
        logic out_free;
    } t_dp_stat;

    // Size in use: at least 3, odd, at most the largest odd value below the maximum
    function automatic logic [FLD_W-1:0] eff_size(input logic [FLD_W-1:0] v, input int lim);
        logic [FLD_W-1:0] n;
        n = v;
        if (n < 6'd3) n = 6'd3;
        if (!n[0]) n = n + 6'd1;
        if (int'(n) > lim) n = FLD_W'(lim);
        return n;
    endfunction

    // Clamp to the interior and force odd
    function automatic logic [FLD_W-1:0] norm_coord(input logic [FLD_W-1:0] v,
                                                    input logic [FLD_W-1:0] size);
        logic [FLD_W-1:0] x;
        x = v;
        if (x < 6'd1) x = 6'd1;
        if (x > size - 6'd2) x = size - 6'd2;
        if (!x[0]) x = x - 6'd1;
        return x;
    endfunction

    // 8-bit value modulo 3: base-4 digits sum to the same residue
    function automatic logic [1:0] mod3_u8(input logic [PICK_W-1:0] p);
        logic [3:0] s;
        s = {2'b00, p[1:0]} + {2'b00, p[3:2]} + {2'b00, p[5:4]} + {2'b00, p[7:6]};
        priority if (s >= 4'd12) s = s - 4'd12;
        else if (s >= 4'd9)      s = s - 4'd9;
        else if (s >= 4'd6)      s = s - 4'd6;
        else if (s >= 4'd3)      s = s - 4'd3;
        return s[1:0];
    endfunction

    function automatic logic [1:0] pick_mod(input logic [PICK_W-1:0] p, input logic [2:0] n);
        logic [1:0] k;
        unique case (n)
            3'd4:    k = p[1:0];
            3'd3:    k = mod3_u8(p);
            3'd2:    k = {1'b0, p[0]};
            default: k = 2'd0;
        endcase
        return k;
    endfunction

    // Direction of the k-th set bit of a move mask
    function automatic t_dir nth_set(input logic [3:0] m, input logic [1:0] k);
        t_dir       d;
        logic [2:0] cnt;
        d   = DIR_UP;
        cnt = '0;
        for (int b = 0; b < 4; b++) begin
            if (m[b]) begin
                if (cnt == {1'b0, k}) d = 2'(b);
                cnt = cnt + 3'd1;
            end
        end
        return d;
    endfunction

    // Cell of a fetched row; anything outside the grid in use reads as wall
    function automatic t_cell cell_at(input t_row w, input logic [6:0] r, input logic [6:0] c,
                                      input logic [FLD_W-1:0] rows,
                                      input logic [FLD_W-1:0] cols);
        t_cell v;
        v = CELL_WALL;
        if (r < {1'b0, rows} && c < {1'b0, cols}) begin
            for (int k = 0; k < MAX_COLS; k++) begin
                if (int'(c) == k) v = w[k];
            end
        end
        return v;
    endfunction

endpackage

// ===== hdl/mcw_if.sv =====
// Request and response channel interfaces of the maze carving walk unit.
interface mcw_req_if import mcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic [FLD_W-1:0]  row;
    logic [FLD_W-1:0]  col;
    logic [PICK_W-1:0] pick;

    modport source (output valid, cmd, row, col, pick, input ready);
    modport sink   (input valid, cmd, row, col, pick, output ready);
endinterface

interface mcw_rsp_if import mcw_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       cell_state;
    logic [1:0]       direction;
    logic             moved;
    logic             retraced;
    logic [FLD_W-1:0] cur_row;
    logic [FLD_W-1:0] cur_col;
    logic             finished;

    modport source (output valid, cell_state, direction, moved, retraced, cur_row, cur_col,
                    finished, input ready);
    modport sink   (input valid, cell_state, direction, moved, retraced, cur_row, cur_col,
                    finished, output ready);
endinterface

// ===== hdl/mcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule

// ===== hdl/mcw_ctrl.sv =====
// Sequencer of the maze carving walk unit: init sweep, step and read sequences.
module mcw_ctrl import mcw_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_ctl
);
    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_INIT     = 13'b0000000000010,
        S_RD_UP    = 13'b0000000000100,
        S_RD_MID   = 13'b0000000001000,
        S_RD_DN    = 13'b0000000010000,
        S_CAP      = 13'b0000000100000,
        S_DECIDE   = 13'b0000001000000,
        S_WR_UP    = 13'b0000010000000,
        S_WR_MID   = 13'b0000100000000,
        S_WR_DN    = 13'b0001000000000,
        S_RD_CELL  = 13'b0010000000000,
        S_CAP_CELL = 13'b0100000000000,
        S_OUT      = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.start = 1'b1;
                    priority if (i_stat.in_init)                  n_state = S_INIT;
                    else if (i_stat.in_step && !i_stat.done)      n_state = S_RD_UP;
                    else if (i_stat.in_read)                      n_state = S_RD_CELL;
                    else                                          n_state = S_OUT;
                end
            end
            S_INIT: begin
                o_ctl.sweep = 1'b1;
                if (i_stat.sweep_last) n_state = S_OUT;
            end
            S_RD_UP: begin
                o_ctl.rd_sel = RS_UP;
                n_state      = S_RD_MID;
            end
            S_RD_MID: begin
                o_ctl.rd_sel  = RS_MID;
                o_ctl.cap_en  = 1'b1;
                o_ctl.cap_sel = RS_UP;
                n_state       = S_RD_DN;
            end
            S_RD_DN: begin
                o_ctl.rd_sel  = RS_DN;
                o_ctl.cap_en  = 1'b1;
                o_ctl.cap_sel = RS_MID;
                n_state       = S_CAP;
            end
            S_CAP: begin
                o_ctl.cap_en  = 1'b1;
                o_ctl.cap_sel = RS_DN;
                n_state       = S_DECIDE;
            end
            S_DECIDE: begin
                o_ctl.decide = 1'b1;
                n_state      = i_stat.any_move ? S_WR_UP : S_OUT;
            end
            S_WR_UP: begin
                o_ctl.wr_en  = 1'b1;
                o_ctl.wr_sel = RS_UP;
                n_state      = S_WR_MID;
            end
            S_WR_MID: begin
                o_ctl.wr_en  = 1'b1;
                o_ctl.wr_sel = RS_MID;
                n_state      = S_WR_DN;
            end
            S_WR_DN: begin
                // last row write still sees the old position
                o_ctl.wr_en   = 1'b1;
                o_ctl.wr_sel  = RS_DN;
                o_ctl.upd_pos = 1'b1;
                n_state       = S_OUT;
            end
            S_RD_CELL: begin
                o_ctl.rd_sel = RS_CELL;
                n_state      = S_CAP_CELL;
            end
            S_CAP_CELL: begin
                o_ctl.cap_en  = 1'b1;
                o_ctl.cap_sel = RS_CELL;
                n_state       = S_OUT;
            end
            S_OUT: begin
                // hold the result until the output register frees up
                if (i_stat.out_free) begin
                    o_ctl.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_one_request_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while another is in progress");

    a_decide_branches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |=> (r_state == S_WR_UP || r_state == S_OUT))
        else $error("decision not followed by write-back or result");
endmodule

// ===== hdl/mcw_dp.sv =====
// Datapath of the maze carving walk unit: grid memory, row buffers, move logic, result.
module mcw_dp import mcw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  t_cfg_idx          i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic [1:0]        i_cmd,
    input  logic [FLD_W-1:0]  i_row,
    input  logic [FLD_W-1:0]  i_col,
    input  logic [PICK_W-1:0] i_pick,
    input  t_dp_cmd           i_ctl,
    output t_dp_stat          o_stat,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [1:0]        o_cell_state,
    output logic [1:0]        o_direction,
    output logic              o_moved,
    output logic              o_retraced,
    output logic [FLD_W-1:0]  o_cur_row,
    output logic [FLD_W-1:0]  o_cur_col,
    output logic              o_finished
);
    logic [FLD_W-1:0]  r_grid_rows;
    logic [FLD_W-1:0]  r_grid_cols;
    logic [FLD_W-1:0]  r_row_in;
    logic [FLD_W-1:0]  r_col_in;
    logic [PICK_W-1:0] r_pick;
    logic [ROW_AW-1:0] r_sweep;
    t_row              r_up;
    t_row              r_mid;
    t_row              r_dn;
    logic [FLD_W-1:0]  r_pos_row;
    logic [FLD_W-1:0]  r_pos_col;
    logic              r_done;
    t_cell             r_cell;
    t_dir              r_dir;
    logic              r_moved;
    logic              r_back;
    logic              r_out_valid;
    t_cell             r_o_cell;
    t_dir              r_o_dir;
    logic              r_o_moved;
    logic              r_o_back;
    logic [FLD_W-1:0]  r_o_row;
    logic [FLD_W-1:0]  r_o_col;
    logic              r_o_done;

    logic [FLD_W-1:0]  rows_eff;
    logic [FLD_W-1:0]  cols_eff;
    logic [FLD_W-1:0]  nrow;
    logic [FLD_W-1:0]  ncol;
    logic [6:0]        ri_up;
    logic [6:0]        ri_mid;
    logic [6:0]        ri_dn;
    logic [6:0]        j7;
    logic [6:0]        jm;
    logic [6:0]        jp;
    logic              sweep_last;

    t_row              sweep_word;
    t_row              upd_word;
    t_row              wr_old;
    logic [6:0]        wr_ri;
    logic [6:0]        j_nb;
    logic              vert;
    logic              is_cur;
    logic              is_nb;
    t_cell             mark;
    logic              row_ok;
    logic              hit_path;
    logic              hit_wall;

    t_cell             nb_up;
    t_cell             nb_dn;
    t_cell             nb_rt;
    t_cell             nb_lf;
    logic [3:0]        f_mask;
    logic [3:0]        b_mask;
    logic [2:0]        f_n;
    logic [2:0]        b_n;
    logic              fwd_any;
    logic              any_move;
    t_dir              pick_dir;

    logic              mem_we;
    logic [ROW_AW-1:0] mem_waddr;
    t_row              mem_wdata;
    logic [ROW_AW-1:0] mem_raddr;
    t_row              mem_rdata;

    assign rows_eff   = eff_size(r_grid_rows, ROW_LIM);
    assign cols_eff   = eff_size(r_grid_cols, COL_LIM);
    assign nrow       = norm_coord(r_row_in, rows_eff);
    assign ncol       = norm_coord(r_col_in, cols_eff);
    assign ri_mid     = {1'b0, r_pos_row};
    assign ri_up      = ri_mid - 7'd1;
    assign ri_dn      = ri_mid + 7'd1;
    assign j7         = {1'b0, r_pos_col};
    assign jm         = j7 - 7'd1;
    assign jp         = j7 + 7'd1;
    assign sweep_last = (r_sweep == ROW_AW'(MAX_ROWS - 1));

    // Init row: border walls, start cell path, everything else (and outside) free
    always_comb begin
        for (int k = 0; k < MAX_COLS; k++) begin
            sweep_word[k] = CELL_FREE;
            if (int'(r_sweep) < int'(rows_eff) && k < int'(cols_eff)) begin
                if (int'(r_sweep) == 0 || int'(r_sweep) == int'(rows_eff) - 1 ||
                    k == 0 || k == int'(cols_eff) - 1) begin
                    sweep_word[k] = CELL_WALL;
                end else if (int'(r_sweep) == int'(nrow) && k == int'(ncol)) begin
                    sweep_word[k] = CELL_PATH;
                end
            end
        end
    end

    // Move choice from the three buffered rows around the current cell
    always_comb begin
        nb_up     = cell_at(r_up, ri_up, j7, rows_eff, cols_eff);
        nb_dn     = cell_at(r_dn, ri_dn, j7, rows_eff, cols_eff);
        nb_rt     = cell_at(r_mid, ri_mid, jp, rows_eff, cols_eff);
        nb_lf     = cell_at(r_mid, ri_mid, jm, rows_eff, cols_eff);
        f_mask[0] = (r_pos_row >= 6'd2) && (nb_up == CELL_FREE);
        f_mask[1] = (ri_mid + 7'd2 < {1'b0, rows_eff}) && (nb_dn == CELL_FREE);
        f_mask[2] = (j7 + 7'd2 < {1'b0, cols_eff}) && (nb_rt == CELL_FREE);
        f_mask[3] = (r_pos_col >= 6'd2) && (nb_lf == CELL_FREE);
        b_mask[0] = (nb_up == CELL_PATH);
        b_mask[1] = (nb_dn == CELL_PATH);
        b_mask[2] = (nb_rt == CELL_PATH);
        b_mask[3] = (nb_lf == CELL_PATH);
        f_n       = 3'($countones(f_mask));
        b_n       = 3'($countones(b_mask));
        fwd_any   = (f_n != 3'd0);
        any_move  = fwd_any || (b_n != 3'd0);
        if (fwd_any) begin
            pick_dir = nth_set(f_mask, pick_mod(r_pick, f_n));
        end else begin
            pick_dir = nth_set(b_mask, pick_mod(r_pick, b_n));
        end
    end

    // Write-back row: carve or retrace the two cells, wall free cells beside a carve
    always_comb begin
        unique case (i_ctl.wr_sel)
            RS_UP: begin
                wr_old = r_up;
                wr_ri  = ri_up;
            end
            RS_DN: begin
                wr_old = r_dn;
                wr_ri  = ri_dn;
            end
            default: begin
                wr_old = r_mid;
                wr_ri  = ri_mid;
            end
        endcase
        unique case (r_dir)
            DIR_RIGHT: j_nb = jp;
            DIR_LEFT:  j_nb = jm;
            default:   j_nb = j7;
        endcase
        vert   = (r_dir == DIR_UP) || (r_dir == DIR_DOWN);
        is_cur = (i_ctl.wr_sel == RS_MID);
        is_nb  = (i_ctl.wr_sel == RS_UP && r_dir == DIR_UP) ||
                 (i_ctl.wr_sel == RS_DN && r_dir == DIR_DOWN);
        mark   = r_back ? CELL_BACK : CELL_PATH;
        row_ok = wr_ri < {1'b0, rows_eff};
        for (int k = 0; k < MAX_COLS; k++) begin
            upd_word[k] = wr_old[k];
            hit_path = (is_cur && (k == int'(j7) || k == int'(j_nb))) ||
                       (is_nb && k == int'(j7));
            hit_wall = !r_back &&
                       (vert ? ((is_cur || is_nb) && (k == int'(jm) || k == int'(jp)))
                             : (!is_cur && (k == int'(j7) || k == int'(j_nb))));
            if (row_ok && k < int'(cols_eff)) begin
                if (hit_path) begin
                    upd_word[k] = mark;
                end else if (hit_wall && wr_old[k] == CELL_FREE) begin
                    upd_word[k] = CELL_WALL;
                end
            end
        end
    end

    always_comb begin
        mem_we    = i_ctl.sweep || (i_ctl.wr_en && int'(wr_ri) < MAX_ROWS);
        mem_waddr = i_ctl.sweep ? r_sweep : ROW_AW'(wr_ri);
        mem_wdata = i_ctl.sweep ? sweep_word : upd_word;
        unique case (i_ctl.rd_sel)
            RS_UP:   mem_raddr = ROW_AW'(ri_up);
            RS_MID:  mem_raddr = ROW_AW'(ri_mid);
            RS_DN:   mem_raddr = ROW_AW'(ri_dn);
            RS_CELL: mem_raddr = ROW_AW'(nrow);
            default: mem_raddr = ROW_AW'(ri_mid);
        endcase
    end

    mcw_ram #(
        .WIDTH (2 * MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_grid (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_wr_addr (mem_waddr),
        .i_wr_data (mem_wdata),
        .i_rd_addr (mem_raddr),
        .o_rd_data (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= GRID_ROWS_RST;
            r_grid_cols <= GRID_COLS_RST;
            r_sweep     <= '0;
            r_pos_row   <= '0;
            r_pos_col   <= '0;
            r_done      <= 1'b0;
            r_moved     <= 1'b0;
            r_back      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_GRID_ROWS: r_grid_rows <= i_cfg_data;
                    CFG_GRID_COLS: r_grid_cols <= i_cfg_data;
                    default:       r_grid_rows <= r_grid_rows;
                endcase
            end
            if (i_ctl.start) begin
                r_row_in <= i_row;
                r_col_in <= i_col;
                r_pick   <= i_pick;
                r_cell   <= CELL_FREE;
                r_dir    <= DIR_UP;
                r_moved  <= 1'b0;
                r_back   <= 1'b0;
                r_sweep  <= '0;
            end
            if (i_ctl.sweep) begin
                r_sweep <= r_sweep + 1'b1;
                if (sweep_last) begin
                    r_pos_row <= nrow;
                    r_pos_col <= ncol;
                    r_done    <= 1'b0;
                end
            end
            if (i_ctl.cap_en) begin
                unique case (i_ctl.cap_sel)
                    RS_UP:   r_up  <= mem_rdata;
                    RS_MID:  r_mid <= mem_rdata;
                    RS_DN:   r_dn  <= mem_rdata;
                    RS_CELL: r_cell <= cell_at(mem_rdata, {1'b0, nrow}, {1'b0, ncol},
                                               rows_eff, cols_eff);
                    default: r_mid <= mem_rdata;
                endcase
            end
            if (i_ctl.decide) begin
                if (any_move) begin
                    r_dir   <= pick_dir;
                    r_moved <= 1'b1;
                    r_back  <= !fwd_any;
                end else begin
                    r_done <= 1'b1;
                end
            end
            if (i_ctl.upd_pos) begin
                // advance two cells, wrapping in six bits
                unique case (r_dir)
                    DIR_UP:    r_pos_row <= r_pos_row - 6'd2;
                    DIR_DOWN:  r_pos_row <= r_pos_row + 6'd2;
                    DIR_RIGHT: r_pos_col <= r_pos_col + 6'd2;
                    DIR_LEFT:  r_pos_col <= r_pos_col - 6'd2;
                    default:   r_pos_col <= r_pos_col;
                endcase
            end
            if (i_ctl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            r_o_cell  <= r_cell;
            r_o_dir   <= r_dir;
            r_o_moved <= r_moved;
            r_o_back  <= r_back;
            r_o_row   <= r_pos_row;
            r_o_col   <= r_pos_col;
            r_o_done  <= r_done;
        end
    end

    assign o_stat.in_init    = (i_cmd == CMD_INIT);
    assign o_stat.in_step    = (i_cmd == CMD_STEP);
    assign o_stat.in_read    = (i_cmd == CMD_READ);
    assign o_stat.done       = r_done;
    assign o_stat.sweep_last = sweep_last;
    assign o_stat.any_move   = any_move;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_cell_state = r_o_cell;
    assign o_direction  = r_o_dir;
    assign o_moved      = r_o_moved;
    assign o_retraced   = r_o_back;
    assign o_cur_row    = r_o_row;
    assign o_cur_col    = r_o_col;
    assign o_finished   = r_o_done;

    a_retrace_is_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_back |-> r_moved)
        else $error("retrace flagged without a move");

    a_start_cell_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.sweep && sweep_last) |=> (r_pos_row[0] && r_pos_col[0]))
        else $error("start cell not on odd coordinates");

    a_move_changes_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.upd_pos |=> (r_pos_row != $past(r_pos_row) || r_pos_col != $past(r_pos_col)))
        else $error("move left the position unchanged");
endmodule

// ===== hdl/maze_carving_walk_unit.sv =====
// Top level of the maze carving walk unit: depth-first maze carving on a row-wide grid memory.
//
// Requests arrive on i_req (valid/ready); each request yields exactly one response on
// o_rsp (valid/ready), in order. cmd init clears the grid, walls the border and places
// the start cell; cmd step carves one move, retraces one move or sets finished; cmd read
// returns one cell. Grid size comes from the write-only registers on i_cfg_*, which the user
// must write only while no request is in flight; the block itself does not enforce this.
// Sequences, request accepted to response valid:
//   init: every grid row is written in turn, one grid row per cycle
//   step: three row reads, decide, then three row writes if there is a move
//   read: one row read and capture; finished step or unknown cmd: straight to the result
// The grid memory reads or writes one row per cycle; one request is
// worked at a time.
// A response waits in the output register while o_rsp.ready is low; the next request is
// still accepted and worked, then held until that register frees up.
// Reset clears position, finished flag and size registers (11 rows, 21 columns); the
// grid content is undefined until the first init.
module maze_carving_walk_unit import mcw_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    mcw_req_if.sink          i_req,
    mcw_rsp_if.source        o_rsp
);
    t_dp_cmd  ctl;
    t_dp_stat stat;
    logic     in_ready;

    mcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    mcw_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (i_req.cmd),
        .i_row        (i_req.row),
        .i_col        (i_req.col),
        .i_pick       (i_req.pick),
        .i_ctl        (ctl),
        .o_stat       (stat),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_cell_state (o_rsp.cell_state),
        .o_direction  (o_rsp.direction),
        .o_moved      (o_rsp.moved),
        .o_retraced   (o_rsp.retraced),
        .o_cur_row    (o_rsp.cur_row),
        .o_cur_col    (o_rsp.cur_col),
        .o_finished   (o_rsp.finished)
    );

    assign i_req.ready = in_ready;
endmodule
